// ===== sv/wlmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wlmf_pkg;

    localparam int MAX_TAPS   = 8;
    localparam int MAX_LINE   = 4096;
    localparam int LABEL_BITS = 8;

    localparam int LABEL_W    = 8;
    localparam int WIN_DEPTH  = 8;
    localparam int WEIGHT_W   = 16;
    localparam int TOTAL_W    = WEIGHT_W + 3;
    localparam int KEY_W      = TOTAL_W + LABEL_W;
    localparam int POS_W      = 12;
    localparam int LEN_W      = 13;
    localparam int TAPS_W     = 4;
    localparam int NUM_W      = 9;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int DRAIN_W    = 3;
    localparam int HALF_W     = 3;
    localparam int QSAT_W     = 4;

    localparam int TAP_LIMIT  = (MAX_TAPS < 8) ? MAX_TAPS : 8;
    localparam logic [LABEL_W-1:0] LABEL_MASK = LABEL_W'((1 << LABEL_BITS) - 1);

    localparam int QPTR_BITS   = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_BITS;
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LABELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 3'd4;

    localparam logic [LEN_W-1:0] LINE_LENGTH_RST  = 13'd256;
    localparam logic [TAPS_W-1:0] MASK_LENGTH_RST = 4'd7;
    localparam logic [NUM_W-1:0] NUM_LABELS_RST   = 9'd256;
    localparam logic [CFG_W-1:0] WEIGHTS_LOW_RST  = 64'd90635973299273744;
    localparam logic [CFG_W-1:0] WEIGHTS_HIGH_RST = 64'd68725768432;

    typedef struct packed {
        logic [LEN_W-1:0]  line_length;
        logic [TAPS_W-1:0] mask_length;
        logic [NUM_W-1:0]  num_labels;
        logic [CFG_W-1:0]  weights_low;
        logic [CFG_W-1:0]  weights_high;
    } cfg_t;

    // one request to the back end: a window snapshot and the results it owes
    typedef struct packed {
        logic [WIN_DEPTH-1:0][LABEL_W-1:0] window;
        logic [LABEL_W-1:0]                first;
        logic [QSAT_W-1:0]                 pos_sat;
        logic [DRAIN_W-1:0]                qstart;
        logic [DRAIN_W-1:0]                count;
        logic                              last;
        logic                              pass;
    } job_t;

    typedef struct packed {
        logic [QCNT_BITS-1:0] fill;
        logic                 push;
        logic                 pop;
    } queue_status_t;

    function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] m);
        return (m > TAPS_W'(TAP_LIMIT)) ? TAPS_W'(TAP_LIMIT) : m;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wlmf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wlmf_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [wlmf_pkg::LABEL_W-1:0]  label,
    input  wire wlmf_pkg::cfg_t                cfg,
    input  wire logic                          queue_full,
    output logic                               push,
    output wlmf_pkg::job_t                     job
);

    logic [wlmf_pkg::WIN_DEPTH-1:0][wlmf_pkg::LABEL_W-1:0] window_reg, window_next;
    logic [wlmf_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [wlmf_pkg::LABEL_W-1:0] first_reg, first_next;
    logic [wlmf_pkg::DRAIN_W-1:0] drain_reg, drain_next;

    logic                         accept;
    logic [wlmf_pkg::LABEL_W-1:0] lab;
    logic [wlmf_pkg::LEN_W-1:0]   len;
    logic [wlmf_pkg::TAPS_W-1:0]  taps;
    logic [wlmf_pkg::HALF_W-1:0]  half;
    logic [wlmf_pkg::DRAIN_W-1:0] drain_inc;
    logic [wlmf_pkg::DRAIN_W-1:0] count;
    logic                         last;
    logic                         pass;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign lab        = label & wlmf_pkg::LABEL_MASK;

    always_comb
    begin
        if (cfg.line_length == '0)
            len = wlmf_pkg::LEN_W'(1);
        else if (cfg.line_length > wlmf_pkg::LEN_W'(wlmf_pkg::MAX_LINE))
            len = wlmf_pkg::LEN_W'(wlmf_pkg::MAX_LINE);
        else
            len = cfg.line_length;

        taps      = wlmf_pkg::eff_taps(cfg.mask_length);
        half      = taps[wlmf_pkg::HALF_W:1];
        drain_inc = drain_reg + 1'b1;
        last      = ({1'b0, pos_reg} + 1'b1) >= len;
        pass      = (len < wlmf_pkg::LEN_W'(2)) || (taps == '0)
                    || (len < wlmf_pkg::LEN_W'(taps));

        if (pass || last)
            count = drain_inc;
        else if (drain_inc > half)
            count = drain_inc - half;
        else
            count = '0;

        first_next  = (pos_reg == '0) ? lab : first_reg;
        window_next = {window_reg[wlmf_pkg::WIN_DEPTH-2:0], lab};
        drain_next  = last ? '0 : drain_inc - count;
        pos_next    = last ? '0 : pos_reg + 1'b1;

        job.window  = window_next;
        job.first   = first_next;
        job.pos_sat = (pos_reg > wlmf_pkg::POS_W'({wlmf_pkg::QSAT_W{1'b1}}))
                      ? {wlmf_pkg::QSAT_W{1'b1}} : pos_reg[wlmf_pkg::QSAT_W-1:0];
        job.qstart  = drain_inc - 1'b1;
        job.count   = count;
        job.last    = last;
        job.pass    = pass;
    end

    // items that release nothing push no request; they only update the window, position and drain state
    assign push = accept && (count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            first_reg  <= '0;
            drain_reg  <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            drain_reg  <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wlmf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wlmf_queue (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire wlmf_pkg::job_t           push_job,
    input  wire logic                     pop,
    output wlmf_pkg::job_t                head,
    output logic                          head_valid,
    output logic                          full,
    output wlmf_pkg::queue_status_t       status
);

    wlmf_pkg::job_t mem_reg [wlmf_pkg::QUEUE_DEPTH];

    logic [wlmf_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [wlmf_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [wlmf_pkg::QCNT_BITS-1:0] fill_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (fill_reg != '0);
    assign full       = (fill_reg == wlmf_pkg::QCNT_BITS'(wlmf_pkg::QUEUE_DEPTH));

    assign status.fill = fill_reg;
    assign status.push = push;
    assign status.pop  = pop;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wlmf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wlmf_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wlmf_pkg::cfg_t                cfg,
    input  wire wlmf_pkg::job_t                head,
    input  wire logic                          head_valid,
    output logic                               pop,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [wlmf_pkg::LABEL_W-1:0]       smoothed_label,
    output logic                               line_end
);

    localparam int N = wlmf_pkg::WIN_DEPTH;

    logic [wlmf_pkg::DRAIN_W-1:0] e_reg;

    logic                                 s1_valid_reg;
    logic [N-1:0][wlmf_pkg::LABEL_W-1:0]  s1_lab_reg;
    logic [N-1:0]                         s1_vote_reg;
    logic [N-1:0]                         s1_tap_reg;
    logic [wlmf_pkg::LABEL_W-1:0]         s1_orig_reg;
    logic                                 s1_end_reg;

    logic                                 s2_valid_reg;
    logic [N-1:0][wlmf_pkg::TOTAL_W-1:0]  s2_total_reg;
    logic [N-1:0][wlmf_pkg::LABEL_W-1:0]  s2_lab_reg;
    logic [N-1:0]                         s2_vote_reg;
    logic [wlmf_pkg::LABEL_W-1:0]         s2_orig_reg;
    logic                                 s2_end_reg;

    logic                                 out_valid_reg;
    logic [wlmf_pkg::LABEL_W-1:0]         out_label_reg;
    logic                                 out_end_reg;

    logic out_ready, s2_ready, s1_ready, issue, job_done;

    logic [wlmf_pkg::TAPS_W-1:0]          taps;
    logic [wlmf_pkg::HALF_W-1:0]          half;
    logic [wlmf_pkg::DRAIN_W-1:0]         q;
    logic [N-1:0][wlmf_pkg::LABEL_W-1:0]  lab_sel;
    logic [N-1:0]                         vote_sel;
    logic [N-1:0]                         tap_sel;
    logic [2*wlmf_pkg::CFG_W-1:0]         wcat;
    logic [N-1:0][wlmf_pkg::TOTAL_W-1:0]  total;
    logic [wlmf_pkg::KEY_W-1:0]           key  [N];
    logic [wlmf_pkg::KEY_W-1:0]           lvl1 [N/2];
    logic [wlmf_pkg::KEY_W-1:0]           lvl2 [N/4];
    logic [wlmf_pkg::KEY_W-1:0]           best;
    logic [wlmf_pkg::LABEL_W-1:0]         winner;

    assign out_ready = !out_valid_reg || !result_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign issue     = head_valid && s1_ready;
    assign job_done  = (e_reg == head.count - 1'b1);
    assign pop       = issue && job_done;

    assign taps = wlmf_pkg::eff_taps(cfg.mask_length);
    assign half = taps[wlmf_pkg::HALF_W:1];
    assign q    = head.qstart - e_reg;
    assign wcat = {cfg.weights_high, cfg.weights_low};

    // tap sources for position q behind the newest label
    always_comb
    begin
        logic signed [5:0] d;
        for (int j = 0; j < N; j++)
        begin
            d = $signed({3'b000, q}) - $signed({3'b000, half}) + 6'(j);
            if (d < 0)
                lab_sel[j] = head.window[0];
            else if (d[4:0] > {1'b0, head.pos_sat})
                lab_sel[j] = head.first;
            else if (d < 6'sd8)
                lab_sel[j] = head.window[d[2:0]];
            else
                lab_sel[j] = head.window[N-1];
            tap_sel[j]  = wlmf_pkg::TAPS_W'(j) < taps;
            vote_sel[j] = tap_sel[j] && ({1'b0, lab_sel[j]} < cfg.num_labels) && !head.pass;
        end
    end

    always_comb
    begin
        logic [wlmf_pkg::TOTAL_W-1:0] acc;
        for (int j = 0; j < N; j++)
        begin
            acc = '0;
            for (int k = 0; k < N; k++)
            begin
                if (s1_tap_reg[k] && (s1_lab_reg[k] == s1_lab_reg[j]))
                    acc = acc + wlmf_pkg::TOTAL_W'(wcat[k*wlmf_pkg::WEIGHT_W +: wlmf_pkg::WEIGHT_W]);
            end
            total[j] = acc;
        end
    end

    // larger total wins; inverted label in the low bits makes ties go low
    always_comb
    begin
        for (int j = 0; j < N; j++)
            key[j] = (s2_vote_reg[j] && (s2_total_reg[j] != '0))
                     ? {s2_total_reg[j], ~s2_lab_reg[j]} : '0;
        for (int j = 0; j < N/2; j++)
            lvl1[j] = (key[2*j] > key[2*j+1]) ? key[2*j] : key[2*j+1];
        for (int j = 0; j < N/4; j++)
            lvl2[j] = (lvl1[2*j] > lvl1[2*j+1]) ? lvl1[2*j] : lvl1[2*j+1];
        best   = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
        winner = (best == '0) ? s2_orig_reg : ~best[wlmf_pkg::LABEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                e_reg <= job_done ? '0 : e_reg + 1'b1;
            if (s1_ready)
                s1_valid_reg <= issue;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_lab_reg  <= lab_sel;
            s1_vote_reg <= vote_sel;
            s1_tap_reg  <= tap_sel;
            s1_orig_reg <= head.window[q];
            s1_end_reg  <= head.last && job_done;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_total_reg <= total;
            s2_lab_reg   <= s1_lab_reg;
            s2_vote_reg  <= s1_vote_reg;
            s2_orig_reg  <= s1_orig_reg;
            s2_end_reg   <= s1_end_reg;
        end
        if (s2_valid_reg && out_ready)
        begin
            out_label_reg <= winner;
            out_end_reg   <= s2_end_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign smoothed_label = out_label_reg;
    assign line_end       = out_end_reg;

endmodule

`default_nettype wire

// ===== sv/weighted_label_mode_filter_top.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------
// item     | item_valid / item_stall    | label[7:0]
// result   | result_valid / result_stall| smoothed_label[7:0], line_end
// config   | cfg_write                  | cfg_index[2:0], cfg_data[63:0]
//
// One label accepted and one result delivered per cycle when neither side stalls.
// The last label of a line releases up to five results at once; the four-entry
// request queue absorbs them and the item side stalls once it is full.
// A released result passes the queue, then the tap select, totals and vote
// registers, before it shows on result_valid.
// rst_n is asynchronous; the window and counters clear at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module weighted_label_mode_filter_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [wlmf_pkg::LABEL_W-1:0]    label,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [wlmf_pkg::LABEL_W-1:0]         smoothed_label,
    output logic                                 line_end,
    input  wire logic                            cfg_write,
    input  wire logic [wlmf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wlmf_pkg::CFG_W-1:0]      cfg_data
);

    logic [wlmf_pkg::LEN_W-1:0]  line_length_reg;
    logic [wlmf_pkg::TAPS_W-1:0] mask_length_reg;
    logic [wlmf_pkg::NUM_W-1:0]  num_labels_reg;
    logic [wlmf_pkg::CFG_W-1:0]  weights_low_reg;
    logic [wlmf_pkg::CFG_W-1:0]  weights_high_reg;

    wlmf_pkg::cfg_t             cfg;
    wlmf_pkg::job_t             push_job;
    wlmf_pkg::job_t             head;
    wlmf_pkg::queue_status_t    q_stat;
    logic                       push, pop, head_valid, queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg  <= wlmf_pkg::LINE_LENGTH_RST;
            mask_length_reg  <= wlmf_pkg::MASK_LENGTH_RST;
            num_labels_reg   <= wlmf_pkg::NUM_LABELS_RST;
            weights_low_reg  <= wlmf_pkg::WEIGHTS_LOW_RST;
            weights_high_reg <= wlmf_pkg::WEIGHTS_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wlmf_pkg::REG_LINE_LENGTH:  line_length_reg  <= cfg_data[wlmf_pkg::LEN_W-1:0];
                wlmf_pkg::REG_MASK_LENGTH:  mask_length_reg  <= cfg_data[wlmf_pkg::TAPS_W-1:0];
                wlmf_pkg::REG_NUM_LABELS:   num_labels_reg   <= cfg_data[wlmf_pkg::NUM_W-1:0];
                wlmf_pkg::REG_WEIGHTS_LOW:  weights_low_reg  <= cfg_data;
                wlmf_pkg::REG_WEIGHTS_HIGH: weights_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.line_length  = line_length_reg;
    assign cfg.mask_length  = mask_length_reg;
    assign cfg.num_labels   = num_labels_reg;
    assign cfg.weights_low  = weights_low_reg;
    assign cfg.weights_high = weights_high_reg;

    wlmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .label      (label),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    wlmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full),
        .status     (q_stat)
    );

    wlmf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .smoothed_label (smoothed_label),
        .line_end       (line_end)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.pop |-> (q_stat.fill != '0))
        else $error("request queue popped while empty");

    a_push_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.push && !q_stat.pop |-> (q_stat.fill != wlmf_pkg::QCNT_BITS'(wlmf_pkg::QUEUE_DEPTH)))
        else $error("request queue pushed while full");

    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.push && !q_stat.pop |=>
            (q_stat.fill == wlmf_pkg::QCNT_BITS'($past(q_stat.fill) + 1'b1)))
        else $error("queue fill did not track a push");

    a_fill_down: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.pop && !q_stat.push |=>
            (q_stat.fill == wlmf_pkg::QCNT_BITS'($past(q_stat.fill) - 1'b1)))
        else $error("queue fill did not track a pop");

endmodule

`default_nettype wire
